// File: design/etfi_pkg.sv
// Package for the escape-time fractal iteration block.
// Holds fixed-point widths, register indexes, FSM state type and shared structs.
// No dependencies.
package etfi_pkg;

	// Fixed-point format: signed Q3.FRAC_BITS
	localparam int FRAC_BITS  = 28;
	localparam int COUNT_BITS = 16;
	localparam int VAL_BITS   = FRAC_BITS + 3;
	// z after one update stays in (-8, 8): one more integer bit than a point
	localparam int Z_BITS     = VAL_BITS + 1;
	localparam int PROD_BITS  = 2 * Z_BITS;
	localparam int SUM_BITS   = PROD_BITS + 1;

	// Escape radius squared, 4.0 at the product scale
	localparam logic [SUM_BITS-1:0] FOUR_SQ = SUM_BITS'(4) << (2 * FRAC_BITS);

	localparam logic [COUNT_BITS-1:0] LIMIT_RESET = COUNT_BITS'(256);

	// APB register map
	localparam int ADDR_BITS = 4;
	localparam int DATA_BITS = 32;

	typedef enum logic [1:0] {
		REG_MODE   = 2'd0,
		REG_C_RE   = 2'd1,
		REG_C_IM   = 2'd2,
		REG_LIMIT  = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQX,
		S_SQY,
		S_MXY,
		S_UPD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                        julia_mode;
		logic signed [VAL_BITS-1:0]  c_real;
		logic signed [VAL_BITS-1:0]  c_imag;
		logic [COUNT_BITS-1:0]       limit;
	} cfg_t;

	typedef struct packed {
		logic                  valid;
		logic [COUNT_BITS-1:0] count;
		logic                  in_set;
	} result_t;

endpackage

// File: design/etfi_regs.sv
// APB configuration registers of the escape-time block.
// Depends on etfi_pkg.
module etfi_regs import etfi_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output cfg_t                 cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[ADDR_BITS-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.julia_mode <= 1'b0;
			cfg_q.c_real     <= '0;
			cfg_q.c_imag     <= '0;
			cfg_q.limit      <= LIMIT_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_MODE:  cfg_q.julia_mode <= pwdata[0];
				REG_C_RE:  cfg_q.c_real     <= pwdata[VAL_BITS-1:0];
				REG_C_IM:  cfg_q.c_imag     <= pwdata[VAL_BITS-1:0];
				REG_LIMIT: cfg_q.limit      <= pwdata[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MODE:  prdata = DATA_BITS'(cfg_q.julia_mode);
			REG_C_RE:  prdata = DATA_BITS'(cfg_q.c_real);
			REG_C_IM:  prdata = DATA_BITS'(cfg_q.c_imag);
			REG_LIMIT: prdata = DATA_BITS'(cfg_q.limit);
			default:   prdata = '0;
		endcase
	end

endmodule

// File: design/etfi_mul.sv
// Shared signed multiplier with a registered product.
// Depends on etfi_pkg.
module etfi_mul import etfi_pkg::*; (
	input  logic                        clk,
	input  logic signed [Z_BITS-1:0]    op_a,
	input  logic signed [Z_BITS-1:0]    op_b,
	output logic signed [PROD_BITS-1:0] prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

endmodule

// File: design/etfi_seq.sv
// Iteration sequencer: holds z and c, steps the shared multiplier through
// x*x, y*y and x*y, then tests for escape and updates z. Depends on etfi_pkg, etfi_mul.
module etfi_seq import etfi_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [VAL_BITS-1:0] point_real,
	input  logic signed [VAL_BITS-1:0] point_imag,
	output result_t                    res,
	input  logic                       res_take
);

	state_t state_q, state_d;

	logic signed [Z_BITS-1:0]    x_q, y_q, cr_q, ci_q;
	logic signed [PROD_BITS-1:0] x2_q, y2_q;
	logic [COUNT_BITS-1:0]       n_q;

	logic signed [Z_BITS-1:0]    op_a, op_b;
	logic signed [PROD_BITS-1:0] prod_s1;

	logic                        accept;
	logic                        at_limit;
	logic [SUM_BITS-1:0]         mag_sq;
	logic                        escape;
	logic signed [SUM_BITS-1:0]  diff;
	logic signed [SUM_BITS-1:0]  diff_sh;
	logic signed [PROD_BITS-1:0] xy_sh;
	logic signed [Z_BITS-1:0]    x_next, y_next;

	etfi_mul u_mul (
		.clk     (clk),
		.op_a    (op_a),
		.op_b    (op_b),
		.prod_s1 (prod_s1)
	);

	assign accept   = in_valid && !in_stall;
	assign at_limit = (n_q == cfg.limit);

	// squares are non-negative, so the magnitude sum is an unsigned add
	assign mag_sq = {1'b0, x2_q} + {1'b0, y2_q};
	assign escape = (mag_sq > FOUR_SQ);

	// floor shifts: arithmetic right shift of the exact products
	assign diff    = {x2_q[PROD_BITS-1], x2_q} - {y2_q[PROD_BITS-1], y2_q};
	assign diff_sh = diff >>> FRAC_BITS;
	assign xy_sh   = prod_s1 >>> (FRAC_BITS - 1);
	assign x_next  = diff_sh[Z_BITS-1:0] + cr_q;
	assign y_next  = xy_sh[Z_BITS-1:0] + ci_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		res.valid  = 1'b0;
		res.count  = n_q;
		res.in_set = at_limit;
		op_a       = x_q;
		op_b       = y_q;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = S_SQX;
				end
			end
			S_SQX: begin
				op_a = x_q;
				op_b = x_q;
				state_d = at_limit ? S_DONE : S_SQY;
			end
			S_SQY: begin
				op_a = y_q;
				op_b = y_q;
				state_d = S_MXY;
			end
			S_MXY: begin
				op_a = x_q;
				op_b = y_q;
				state_d = S_UPD;
			end
			S_UPD: begin
				state_d = escape ? S_DONE : S_SQX;
			end
			S_DONE: begin
				res.valid = 1'b1;
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q <= '0;
			if (cfg.julia_mode) begin
				x_q  <= Z_BITS'(point_real);
				y_q  <= Z_BITS'(point_imag);
				cr_q <= Z_BITS'(cfg.c_real);
				ci_q <= Z_BITS'(cfg.c_imag);
			end else begin
				x_q  <= '0;
				y_q  <= '0;
				cr_q <= Z_BITS'(point_real);
				ci_q <= Z_BITS'(point_imag);
			end
		end
		if (state_q == S_SQY) begin
			x2_q <= prod_s1;
		end
		if (state_q == S_MXY) begin
			y2_q <= prod_s1;
		end
		if (state_q == S_UPD && !escape) begin
			x_q <= x_next;
			y_q <= y_next;
			n_q <= n_q + 1'b1;
		end
	end

endmodule

// File: design/escape_time_fractal_iteration.sv
// Escape-time iteration (Mandelbrot / Julia) top level.
// Depends on etfi_pkg, etfi_regs, etfi_seq (which holds etfi_mul).
//
//   channel   direction   handshake           payload
//   -------   ---------   -----------------   ---------------------------------
//   in        request in  in_valid/in_stall   point_real, point_imag (Q3.28)
//   out       request out out_valid/out_stall escape_count, inside_set
//   cfg       APB slave   psel/penable/pready julia_mode, julia_c_real/imag,
//                                             iteration_limit
//
// One request at a time. Each update of z steps through S_SQX, S_SQY, S_MXY
// and S_UPD: the single 32x32 multiplier forms x*x, y*y and x*y in turn, then
// S_UPD tests |z|^2 > 4 and, unless z escaped, writes the new z.
// Reset (arst_n low) returns the sequencer to idle, clears the output valid
// flag and resets the configuration (Mandelbrot mode, c = 0, limit 256).
// A stalled result waits in the output register; the next request can be
// taken while it waits, and the sequencer holds its own finished result only
// if the output register is still full.
module escape_time_fractal_iteration import etfi_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	// input request channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [VAL_BITS-1:0]  point_real,
	input  logic signed [VAL_BITS-1:0]  point_imag,
	// output request channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [COUNT_BITS-1:0]       escape_count,
	output logic                        inside_set,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ADDR_BITS-1:0]        paddr,
	input  logic [DATA_BITS-1:0]        pwdata,
	output logic [DATA_BITS-1:0]        prdata,
	output logic                        pready
);

	cfg_t    cfg;
	result_t res;
	logic    res_take;

	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  inside_q;

	assign pready = 1'b1;

	etfi_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	etfi_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.point_real (point_real),
		.point_imag (point_imag),
		.res        (res),
		.res_take   (res_take)
	);

	// Output register: take a finished result when empty or being drained.
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload needs no reset; it only advances with a handoff
	always_ff @(posedge clk) begin
		if (res.valid && res_take) begin
			count_q  <= res.count;
			inside_q <= res.in_set;
		end
	end

	assign out_valid    = out_valid_q;
	assign escape_count = count_q;
	assign inside_set   = inside_q;

	// A flagged inside point reports exactly the configured limit.
	a_inside_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && inside_set |-> escape_count == cfg.limit)
		else $error("inside_set without count at limit");

	// An escaped point always reports fewer updates than the limit.
	a_escape_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !inside_set |-> escape_count < cfg.limit)
		else $error("escaped count not below limit");

	// Once a request is taken the block is busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while previous one still iterating");

endmodule
